>>> rtl/cpu6502_register_alu_execute_assert.svh
// assertion macros used by the checker of the 6502 register/alu execute block
// expects clk and arst_n visible at the point of use
`ifndef CPU6502_REGISTER_ALU_EXECUTE_ASSERT_SVH
`define CPU6502_REGISTER_ALU_EXECUTE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CPU6502_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpu6502 same-cycle check failed");

// next-cycle implication, disabled while in reset
`define CPU6502_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpu6502 next-cycle check failed");

`endif

>>> rtl/cpu6502_pkg.sv
// types and constants for the 6502 register/alu execute block
// no dependencies
package cpu6502_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_INC = 6'd2,  OP_DEC = 6'd3,
		OP_INX = 6'd4,  OP_INY = 6'd5,  OP_DEX = 6'd6,  OP_DEY = 6'd7,
		OP_AND = 6'd8,  OP_ORA = 6'd9,  OP_EOR = 6'd10, OP_ASLA = 6'd11,
		OP_ASLM = 6'd12, OP_LSRA = 6'd13, OP_LSRM = 6'd14, OP_ROLA = 6'd15,
		OP_ROLM = 6'd16, OP_RORA = 6'd17, OP_RORM = 6'd18, OP_BIT = 6'd19,
		OP_CMP = 6'd20, OP_CPX = 6'd21, OP_CPY = 6'd22, OP_LDA = 6'd23,
		OP_LDX = 6'd24, OP_LDY = 6'd25, OP_STA = 6'd26, OP_STX = 6'd27,
		OP_STY = 6'd28, OP_TAX = 6'd29, OP_TAY = 6'd30, OP_TSX = 6'd31,
		OP_TXA = 6'd32, OP_TXS = 6'd33, OP_TYA = 6'd34, OP_CLC = 6'd35,
		OP_CLD = 6'd36, OP_CLI = 6'd37, OP_CLV = 6'd38, OP_SEC = 6'd39,
		OP_SED = 6'd40, OP_SEI = 6'd41, OP_BCC = 6'd42, OP_BCS = 6'd43,
		OP_BEQ = 6'd44, OP_BMI = 6'd45, OP_BNE = 6'd46, OP_BPL = 6'd47,
		OP_BVC = 6'd48, OP_BVS = 6'd49, OP_PLP = 6'd50, OP_NOP = 6'd51
	} op_t;

	// status bit positions
	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_I = 2;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_R = 5;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	localparam logic [7:0] RST_ACC    = 8'h00;
	localparam logic [7:0] RST_INDEX  = 8'h00;
	localparam logic [7:0] RST_STATUS = 8'h24;
	localparam logic [7:0] RST_SP     = 8'hFF;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] p;
		logic [7:0] sp;
	} regs_t;

	typedef struct packed {
		logic [7:0] mem_value;
		logic       mem_write;
		logic       branch_taken;
	} alu_res_t;

endpackage

>>> rtl/cpu6502_alu.sv
// combinational 6502 alu: one operation on the register set and an operand byte
// depends on cpu6502_pkg
module cpu6502_alu
	import cpu6502_pkg::*;
(
	input  logic [5:0] op,
	input  logic [7:0] operand,
	input  regs_t      cur,
	output regs_t      nxt,
	output alu_res_t   res
);

	function automatic logic [7:0] with_nz(input logic [7:0] pin, input logic [7:0] v);
		logic [7:0] p;
		p = pin;
		p[FLAG_N] = v[7];
		p[FLAG_Z] = (v == 8'h00);
		return p;
	endfunction

	logic [8:0] bin_sum;
	logic [8:0] sbc_diff;
	logic [9:0] dec_t1;
	logic [4:0] dec_lo;
	logic [9:0] dec_t2;
	logic [5:0] dec_hi;
	logic       dec_hc;
	logic [9:0] dec_t3;
	logic [7:0] adc_val;
	logic [8:0] cmp_diff;
	logic [7:0] cmp_reg;
	logic [7:0] sh_in;
	logic [7:0] sh_out;
	logic       cin;

	// adders, compare and shifter for the arithmetic, compare and shift ops
	always_comb begin
		cin = cur.p[FLAG_C];
		bin_sum  = {1'b0, cur.acc} + {1'b0, operand} + {8'h00, cin};
		sbc_diff = {1'b0, cur.acc} - {1'b0, operand} - {8'h00, ~cin};
		// packed bcd add, low digit then high digit
		dec_t1 = {2'b00, cur.acc} + {9'h000, cin};
		dec_lo = {1'b0, dec_t1[3:0]} + {1'b0, operand[3:0]};
		dec_t2 = dec_t1 + {6'h00, operand[3:0]} + ((dec_lo > 5'd9) ? 10'd6 : 10'd0);
		dec_hi = dec_t2[9:4] + {2'b00, operand[7:4]};
		dec_hc = (dec_hi > 6'd9);
		dec_t3 = dec_t2 + {2'b00, operand[7:4], 4'h0} + (dec_hc ? 10'h060 : 10'h000);
		adc_val = cur.p[FLAG_D] ? dec_t3[7:0] : bin_sum[7:0];
		case (op)
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = cur.acc;
		endcase
		cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};
		case (op)
			OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA: sh_in = cur.acc;
			default:                            sh_in = operand;
		endcase
		case (op)
			OP_ASLA, OP_ASLM: sh_out = {sh_in[6:0], 1'b0};
			OP_ROLA, OP_ROLM: sh_out = {sh_in[6:0], cin};
			OP_RORA, OP_RORM: sh_out = {cin, sh_in[7:1]};
			default:          sh_out = {1'b0, sh_in[7:1]};
		endcase
	end

	always_comb begin
		nxt = cur;
		res = '0;
		case (op)
			OP_ADC: begin
				nxt.acc = adc_val;
				nxt.p = with_nz(cur.p, adc_val);
				if (cur.p[FLAG_D]) begin
					nxt.p[FLAG_C] = dec_hc;
					nxt.p[FLAG_V] = dec_hc;
				end else begin
					nxt.p[FLAG_C] = bin_sum[8];
					nxt.p[FLAG_V] = ~(cur.acc[7] ^ operand[7]) & (cur.acc[7] ^ bin_sum[7]);
				end
			end
			OP_SBC: begin
				nxt.acc = sbc_diff[7:0];
				nxt.p = with_nz(cur.p, sbc_diff[7:0]);
				nxt.p[FLAG_C] = ~sbc_diff[8];
				nxt.p[FLAG_V] = (cur.acc[7] ^ operand[7]) & (cur.acc[7] ^ sbc_diff[7]);
			end
			OP_INC: begin
				res.mem_value = operand + 8'd1;
				res.mem_write = 1'b1;
				nxt.p = with_nz(cur.p, operand + 8'd1);
			end
			OP_DEC: begin
				res.mem_value = operand - 8'd1;
				res.mem_write = 1'b1;
				nxt.p = with_nz(cur.p, operand - 8'd1);
			end
			OP_INX: begin
				nxt.x = cur.x + 8'd1;
				nxt.p = with_nz(cur.p, cur.x + 8'd1);
			end
			OP_INY: begin
				nxt.y = cur.y + 8'd1;
				nxt.p = with_nz(cur.p, cur.y + 8'd1);
			end
			OP_DEX: begin
				nxt.x = cur.x - 8'd1;
				nxt.p = with_nz(cur.p, cur.x - 8'd1);
			end
			OP_DEY: begin
				nxt.y = cur.y - 8'd1;
				nxt.p = with_nz(cur.p, cur.y - 8'd1);
			end
			OP_AND: begin
				nxt.acc = cur.acc & operand;
				nxt.p = with_nz(cur.p, cur.acc & operand);
			end
			OP_ORA: begin
				nxt.acc = cur.acc | operand;
				nxt.p = with_nz(cur.p, cur.acc | operand);
			end
			OP_EOR: begin
				nxt.acc = cur.acc ^ operand;
				nxt.p = with_nz(cur.p, cur.acc ^ operand);
			end
			OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA: begin
				nxt.acc = sh_out;
				nxt.p = with_nz(cur.p, sh_out);
				nxt.p[FLAG_C] = (op == OP_ASLA || op == OP_ROLA) ? sh_in[7] : sh_in[0];
			end
			OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM: begin
				res.mem_value = sh_out;
				res.mem_write = 1'b1;
				nxt.p = with_nz(cur.p, sh_out);
				nxt.p[FLAG_C] = (op == OP_ASLM || op == OP_ROLM) ? sh_in[7] : sh_in[0];
			end
			OP_BIT: begin
				nxt.p[FLAG_N] = operand[7];
				nxt.p[FLAG_V] = operand[6];
				nxt.p[FLAG_Z] = ((operand & cur.acc) == 8'h00);
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.p = with_nz(cur.p, cmp_diff[7:0]);
				nxt.p[FLAG_C] = ~cmp_diff[8];
			end
			OP_LDA: begin
				nxt.acc = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			OP_LDX: begin
				nxt.x = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			OP_LDY: begin
				nxt.y = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			OP_STA: begin
				res.mem_value = cur.acc;
				res.mem_write = 1'b1;
			end
			OP_STX: begin
				res.mem_value = cur.x;
				res.mem_write = 1'b1;
			end
			OP_STY: begin
				res.mem_value = cur.y;
				res.mem_write = 1'b1;
			end
			OP_TAX: begin
				nxt.x = cur.acc;
				nxt.p = with_nz(cur.p, cur.acc);
			end
			OP_TAY: begin
				nxt.y = cur.acc;
				nxt.p = with_nz(cur.p, cur.acc);
			end
			OP_TSX: begin
				nxt.x = cur.sp;
				nxt.p = with_nz(cur.p, cur.sp);
			end
			OP_TXA: begin
				nxt.acc = cur.x;
				nxt.p = with_nz(cur.p, cur.x);
			end
			OP_TXS: nxt.sp = cur.x;
			OP_TYA: begin
				nxt.acc = cur.y;
				nxt.p = with_nz(cur.p, cur.y);
			end
			OP_CLC: nxt.p[FLAG_C] = 1'b0;
			OP_CLD: nxt.p[FLAG_D] = 1'b0;
			OP_CLI: nxt.p[FLAG_I] = 1'b0;
			OP_CLV: nxt.p[FLAG_V] = 1'b0;
			OP_SEC: nxt.p[FLAG_C] = 1'b1;
			OP_SED: nxt.p[FLAG_D] = 1'b1;
			OP_SEI: nxt.p[FLAG_I] = 1'b1;
			OP_BCC: res.branch_taken = ~cur.p[FLAG_C];
			OP_BCS: res.branch_taken = cur.p[FLAG_C];
			OP_BEQ: res.branch_taken = cur.p[FLAG_Z];
			OP_BMI: res.branch_taken = cur.p[FLAG_N];
			OP_BNE: res.branch_taken = ~cur.p[FLAG_Z];
			OP_BPL: res.branch_taken = ~cur.p[FLAG_N];
			OP_BVC: res.branch_taken = ~cur.p[FLAG_V];
			OP_BVS: res.branch_taken = cur.p[FLAG_V];
			OP_PLP: begin
				nxt.p = operand;
				nxt.p[FLAG_R] = 1'b1;
			end
			// nop and unassigned codes leave everything as is
			default: nxt = cur;
		endcase
	end

endmodule

>>> rtl/cpu6502_register_alu_execute.sv
// top level of the 6502 register/alu execute block
// depends on cpu6502_pkg and cpu6502_alu
//
// usage
//  - input channel (in_valid/in_ready) carries one decoded operation per
//    transaction: op code and the operand byte already fetched for it
//  - output channel (out_valid/out_ready) carries one result per input
//    transaction: write-back byte with its strobe, branch-taken bit and the
//    full register set (a, x, y, status, sp) after the operation
//  - pipeline: the input register is stage one, the alu sits between it and
//    the result register, from which the receiver takes the result
//  - throughput: one operation per cycle while out_ready is held high; the
//    register file is updated at the same edge a result is loaded, so the
//    next operation in stage one sees it
//  - stall: while the receiver holds out_ready low the result holds, the
//    register file holds, and stage one fills once before in_ready drops
//  - reset: a = x = y = 0, status = 0x24, sp = 0xff, both stages empty
module cpu6502_register_alu_execute
	import cpu6502_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [5:0] op,
	input  logic [7:0] operand,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] mem_value,
	output logic       mem_write,
	output logic       branch_taken,
	output logic [7:0] acc,
	output logic [7:0] index_x,
	output logic [7:0] index_y,
	output logic [7:0] status,
	output logic [7:0] stack_ptr
);

	// stage one: captured transaction
	logic       valid_s1;
	logic [5:0] op_s1;
	logic [7:0] operand_s1;

	// architectural registers, also the register part of the result
	regs_t      regs_q;
	regs_t      regs_next;
	alu_res_t   alu_res;

	// result register
	logic       out_valid_q;
	alu_res_t   res_q;

	logic       advance;

	// stage one moves into the result register when that is empty or draining
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op;
			operand_s1 <= operand;
		end
	end

	cpu6502_alu u_alu (
		.op      (op_s1),
		.operand (operand_s1),
		.cur     (regs_q),
		.nxt     (regs_next),
		.res     (alu_res)
	);

	// register file commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.acc <= RST_ACC;
			regs_q.x   <= RST_INDEX;
			regs_q.y   <= RST_INDEX;
			regs_q.p   <= RST_STATUS;
			regs_q.sp  <= RST_SP;
		end else if (advance) begin
			regs_q <= regs_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= alu_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign mem_value    = res_q.mem_value;
	assign mem_write    = res_q.mem_write;
	assign branch_taken = res_q.branch_taken;
	assign acc          = regs_q.acc;
	assign index_x      = regs_q.x;
	assign index_y      = regs_q.y;
	assign status       = regs_q.p;
	assign stack_ptr    = regs_q.sp;

endmodule

>>> rtl/cpu6502_checker.sv
// port-level checks for the 6502 register/alu execute block, bound to the top level
// depends on cpu6502_register_alu_execute_assert.svh
`include "cpu6502_register_alu_execute_assert.svh"

module cpu6502_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] mem_value,
	input logic       mem_write,
	input logic       branch_taken,
	input logic [7:0] acc,
	input logic [7:0] status
);

	// reserved status bit reads as one in every result
	`CPU6502_ASSERT_IMPLY(a_status_reserved, out_valid, status[5])
	// no write-back value without a write strobe, and never write and branch together
	`CPU6502_ASSERT_IMPLY(a_idle_write, out_valid && !mem_write, mem_value == 8'h00 && 1'b1)
	`CPU6502_ASSERT_IMPLY(a_write_no_branch, out_valid, !(mem_write && branch_taken))
	// an empty result register always leaves room for a new transaction
	`CPU6502_ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready)
	// a stalled result keeps its registers
	`CPU6502_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(acc) && $stable(status))

endmodule

bind cpu6502_register_alu_execute cpu6502_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.mem_value    (mem_value),
	.mem_write    (mem_write),
	.branch_taken (branch_taken),
	.acc          (acc),
	.status       (status)
);
